// File: sv/tkf_pkg.sv
// shared types, widths and register codes of the top-k frequency recommender
`timescale 1ns / 1ps

package tkf_pkg;

    // fixed field widths
    localparam int VALUE_W = 10;
    localparam int RANK_W  = 4;
    localparam int TOPK_W  = 5;

    // parameter defaults
    localparam int DEF_VALUE_COUNT = 1024;
    localparam int DEF_MAX_K       = 16;
    localparam int DEF_COUNT_BITS  = 16;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [TOPK_W-1:0] TOPK_RESET = 5'd10;

    // register index, taken from paddr[APB_AW-1:2]
    localparam logic [APB_AW-3:0] REG_TOP_K = 1'b0;

    // input word
    typedef struct packed {
        logic [VALUE_W-1:0] item_value;
    } tkf_item_t;

    // result word
    typedef struct packed {
        logic [VALUE_W-1:0] query_value;
        logic [VALUE_W-1:0] recommended_value;
        logic [RANK_W-1:0]  rank;
        logic               last;
    } tkf_rec_t;

endpackage

// File: sv/tkf_ifs.sv
// valid/ready stream interfaces for the input and result channels
`timescale 1ns / 1ps

interface tkf_item_if;
    logic               valid;
    logic               ready;
    tkf_pkg::tkf_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tkf_rec_if;
    logic              valid;
    logic              ready;
    tkf_pkg::tkf_rec_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/stream_top_k_frequency_recommender.sv
// top level of the streaming top-k frequent item recommender
//
//  channel   dir  handshake          payload
//  item_in   in   valid/ready        item_value
//  rec_out   out  valid/ready        query_value, recommended_value, rank, last
//  apb       in   psel/penable       top_k at byte address 0
//
// a word is accepted, then reported as n result words (n = min(list length, top_k),
// top_k read as 1 when zero and as MAX_K above it); then its count is updated, the top
// list searched one entry at a time, the list tail checked when the list is full and
// the entry bubbled one swap at a time: the single list read port and ranking compare set this.
// after reset the count table is cleared one entry a cycle, all VALUE_COUNT entries,
// with item_in.ready low; apb writes are taken meanwhile.
// a stalled rec_out holds the report until taken; item_in stays low until the run ends.
`timescale 1ns / 1ps

module stream_top_k_frequency_recommender #(
    parameter int VALUE_COUNT = tkf_pkg::DEF_VALUE_COUNT,
    parameter int MAX_K       = tkf_pkg::DEF_MAX_K,
    parameter int COUNT_BITS  = tkf_pkg::DEF_COUNT_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tkf_item_if.sink                    item_in,
    tkf_rec_if.source                   rec_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tkf_pkg::APB_AW-1:0]  paddr,
    input  logic [tkf_pkg::APB_DW-1:0]  pwdata,
    output logic [tkf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    import tkf_pkg::*;

    localparam int AW = $clog2(VALUE_COUNT);

    logic [TOPK_W-1:0]     top_k;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    // configuration registers
    tkf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .top_k   (top_k)
    );

    // per-value occurrence counts
    tkf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (VALUE_COUNT)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer with top list
    tkf_seq #(
        .VALUE_COUNT (VALUE_COUNT),
        .MAX_K       (MAX_K),
        .COUNT_BITS  (COUNT_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .top_k     (top_k),
        .item_in   (item_in),
        .rec_out   (rec_out),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

// File: sv/tkf_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tkf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/tkf_apb_regs.sv
// apb register block holding top_k
`timescale 1ns / 1ps

module tkf_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tkf_pkg::APB_AW-1:0]  paddr,
    input  logic [tkf_pkg::APB_DW-1:0]  pwdata,
    output logic [tkf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [tkf_pkg::TOPK_W-1:0]  top_k
);

    import tkf_pkg::*;

    logic [TOPK_W-1:0] top_k_reg;
    logic [TOPK_W-1:0] top_k_next;
    logic [APB_AW-3:0] reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign top_k   = top_k_reg;

    // register write decode
    always_comb
    begin
        top_k_next = top_k_reg;
        if (wr_en && (reg_idx == REG_TOP_K))
        begin
            top_k_next = pwdata[TOPK_W-1:0];
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_TOP_K: prdata = APB_DW'(top_k_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_k_reg <= TOPK_RESET;
        end
        else
        begin
            top_k_reg <= top_k_next;
        end
    end

endmodule

// File: sv/tkf_seq.sv
// sequencer: count table upkeep, top list storage, shared ranking compare
`timescale 1ns / 1ps

module tkf_seq #(
    parameter int VALUE_COUNT = tkf_pkg::DEF_VALUE_COUNT,
    parameter int MAX_K       = tkf_pkg::DEF_MAX_K,
    parameter int COUNT_BITS  = tkf_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tkf_pkg::TOPK_W-1:0]     top_k,
    tkf_item_if.sink                       item_in,
    tkf_rec_if.source                      rec_out,
    output logic                           ram_we,
    output logic [$clog2(VALUE_COUNT)-1:0] ram_waddr,
    output logic [COUNT_BITS-1:0]          ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(VALUE_COUNT)-1:0] ram_raddr,
    input  logic [COUNT_BITS-1:0]          ram_rdata
);

    import tkf_pkg::*;

    localparam int AW    = $clog2(VALUE_COUNT);
    localparam int LW    = $clog2(MAX_K + 1);
    localparam int IW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int EXT_W = ($clog2(VALUE_COUNT + 1) > VALUE_W) ?
                           $clog2(VALUE_COUNT + 1) : VALUE_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EMIT,
        S_UPDATE,
        S_SEARCH,
        S_CHECK,
        S_BUBBLE
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [LW-1:0]          n_reg, n_next;
    logic [LW-1:0]          idx_reg, idx_next;
    logic [LW-1:0]          len_reg, len_next;
    logic [VALUE_W-1:0]     list_val_reg [MAX_K];
    logic [VALUE_W-1:0]     list_val_next [MAX_K];
    logic [COUNT_BITS-1:0]  list_cnt_reg [MAX_K];
    logic [COUNT_BITS-1:0]  list_cnt_next [MAX_K];
    logic                   out_valid_reg, out_valid_next;
    tkf_rec_t               out_data_reg, out_data_next;

    logic [IW-1:0]          rd_idx;
    logic [VALUE_W-1:0]     rd_val;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic                   mv_before;
    logic [LW-1:0]          k_eff;
    logic                   in_range;

    assign item_in.ready = (state_reg == S_IDLE);
    assign rec_out.valid = out_valid_reg;
    assign rec_out.data  = out_data_reg;

    // effective report length
    always_comb
    begin
        if (top_k == '0)
        begin
            k_eff = LW'(1);
        end
        else if (int'(top_k) > MAX_K)
        begin
            k_eff = LW'(MAX_K);
        end
        else
        begin
            k_eff = LW'(top_k);
        end
    end

    assign in_range = EXT_W'(val_reg) < EXT_W'(VALUE_COUNT);

    // list read port address
    always_comb
    begin
        case (state_reg)
            S_EMIT:   rd_idx = idx_reg[IW-1:0];
            S_SEARCH: rd_idx = idx_reg[IW-1:0];
            S_CHECK:  rd_idx = IW'(MAX_K - 1);
            S_BUBBLE: rd_idx = IW'(idx_reg - LW'(1));
            default:  rd_idx = '0;
        endcase
    end

    assign rd_val = list_val_reg[rd_idx];
    assign rd_cnt = list_cnt_reg[rd_idx];

    // shared ranking compare: moving entry ahead of the entry read
    assign mv_before = (cnt_reg != rd_cnt) ? (cnt_reg > rd_cnt) : (val_reg < rd_val);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        list_val_next  = list_val_reg;
        list_cnt_next  = list_cnt_reg;
        out_valid_next = out_valid_reg && !rec_out.ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(val_reg);
        ram_wdata      = cnt_reg;
        ram_re         = 1'b0;
        ram_raddr      = AW'(item_in.data.item_value);

        case (state_reg)
            // zero the count table after reset
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == AW'(VALUE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            // take a word and fetch its count
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    val_next = item_in.data.item_value;
                    ram_re   = 1'b1;
                    idx_next = '0;
                    n_next   = (len_reg < k_eff) ? len_reg : k_eff;
                    if (((len_reg < k_eff) ? len_reg : k_eff) == '0)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            // one result word per rank
            S_EMIT:
            begin
                if (!out_valid_reg || rec_out.ready)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.query_value       = val_reg;
                    out_data_next.recommended_value = rd_val;
                    out_data_next.rank              = RANK_W'(idx_reg);
                    out_data_next.last              = (idx_reg == n_reg - LW'(1));
                    if (idx_reg == n_reg - LW'(1))
                    begin
                        idx_next   = '0;
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        idx_next = idx_reg + LW'(1);
                    end
                end
            end

            // bump the count unless out of range or saturated
            S_UPDATE:
            begin
                idx_next = '0;
                if (!in_range || (ram_rdata == '1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = ram_rdata + COUNT_BITS'(1);
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata + COUNT_BITS'(1);
                    state_next = S_SEARCH;
                end
            end

            // look for the value in the list, one entry a cycle
            S_SEARCH:
            begin
                if (idx_reg == len_reg)
                begin
                    if (int'(len_reg) < MAX_K)
                    begin
                        len_next   = len_reg + LW'(1);
                        state_next = S_BUBBLE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else if (rd_val == val_reg)
                begin
                    state_next = S_BUBBLE;
                end
                else
                begin
                    idx_next = idx_reg + LW'(1);
                end
            end

            // full list: replace the tail entry only if the new one ranks ahead
            S_CHECK:
            begin
                if (mv_before)
                begin
                    idx_next   = LW'(MAX_K - 1);
                    state_next = S_BUBBLE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // move the entry toward the front, one swap a cycle
            S_BUBBLE:
            begin
                if ((idx_reg != '0) && mv_before)
                begin
                    list_val_next[idx_reg[IW-1:0]] = rd_val;
                    list_cnt_next[idx_reg[IW-1:0]] = rd_cnt;
                    idx_next                       = idx_reg - LW'(1);
                end
                else
                begin
                    list_val_next[idx_reg[IW-1:0]] = val_reg;
                    list_cnt_next[idx_reg[IW-1:0]] = cnt_reg;
                    state_next                     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            val_reg       <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_data_reg  <= '0;
            for (int i = 0; i < MAX_K; i++)
            begin
                list_val_reg[i] <= '0;
                list_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            val_reg       <= val_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_data_reg  <= out_data_next;
            list_val_reg  <= list_val_next;
            list_cnt_reg  <= list_cnt_next;
        end
    end

    // list never outgrows its storage
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(len_reg) <= MAX_K)
        else $error("top list length beyond capacity");

    // list grows by at most one entry at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != $past(len_reg) |-> len_reg == $past(len_reg) + LW'(1))
        else $error("top list length jumped");

    // no result and no accepted word while the count table is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_valid_reg && !item_in.ready)
        else $error("activity during count table clear");

    // each bubble step moves exactly one place toward the front
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BUBBLE ##1 state_reg == S_BUBBLE
        |-> idx_reg == $past(idx_reg) - LW'(1))
        else $error("bubble position did not step");

    // an accepted word always starts a run
    assert property (@(posedge clk) disable iff (!rst_n)
        item_in.valid && item_in.ready |=> state_reg != S_IDLE)
        else $error("accepted word dropped");

endmodule

// File: tb/tb_stream_top_k_frequency_recommender.sv
// self-checking testbench of the streaming top-k frequency recommender
`timescale 1ns / 1ps

module tb_stream_top_k_frequency_recommender;

    import tkf_pkg::*;

    localparam int VALUE_COUNT = DEF_VALUE_COUNT;
    localparam int MAX_K       = DEF_MAX_K;
    localparam int COUNT_BITS  = DEF_COUNT_BITS;
    localparam int HOT_N       = 24;
    // cycles the block may still spend on a count update after its last word
    localparam int SETTLE      = 3 * MAX_K + 32;
    localparam int IDLE_LIMIT  = 4000;

    logic clk = 1'b0;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    tkf_item_if item_bus ();
    tkf_rec_if  rec_bus ();

    stream_top_k_frequency_recommender dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_bus),
        .rec_out (rec_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // mirror of the block: count table, sorted top list and top_k setting
    logic [COUNT_BITS-1:0] hit_count [VALUE_COUNT];
    logic [VALUE_W-1:0]    top_val [MAX_K];
    logic [COUNT_BITS-1:0] top_cnt [MAX_K];
    int                    top_len;
    logic [TOPK_W-1:0]     k_cfg;

    tkf_rec_t           rec_due [$];
    logic [VALUE_W-1:0] pending_items [$];
    logic [VALUE_W-1:0] hot_pool [HOT_N];

    // opening words: empty list, extremes, ties, a short list, then a capped one
    logic [VALUE_W-1:0] opening [20] = '{
        10'd1023, 10'd0, 10'd0, 10'd1023, 10'd512, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5,
        10'd6, 10'd7, 10'd8, 10'd9, 10'd10, 10'd10, 10'd10, 10'd341, 10'd682, 10'd0
    };

    logic calm;
    logic item_taken;
    int   err_count;
    int   idle_cycles;
    int   gap_left;
    int   burst_left;
    int   stall_left;
    tkf_rec_t want;
    tkf_rec_t got;

    // true when entry (va, ca) ranks ahead of entry (vb, cb)
    function automatic bit ahead_of(input logic [VALUE_W-1:0] va,
                                    input logic [COUNT_BITS-1:0] ca,
                                    input logic [VALUE_W-1:0] vb,
                                    input logic [COUNT_BITS-1:0] cb);
        if (ca != cb)
            return ca > cb;
        return va < vb;
    endfunction

    // move an entry toward the front until the list is sorted again
    function automatic void sift_up(input int start);
        int                    pos;
        logic [VALUE_W-1:0]    tv;
        logic [COUNT_BITS-1:0] tc;
        pos = start;
        while (pos > 0 && pos < MAX_K &&
               ahead_of(top_val[pos], top_cnt[pos], top_val[pos-1], top_cnt[pos-1]))
        begin
            tv             = top_val[pos];
            tc             = top_cnt[pos];
            top_val[pos]   = top_val[pos-1];
            top_cnt[pos]   = top_cnt[pos-1];
            top_val[pos-1] = tv;
            top_cnt[pos-1] = tc;
            pos--;
        end
    endfunction

    // count one hit of v and keep the top list in rank order
    function automatic void tally_hit(input logic [VALUE_W-1:0] v);
        int                    pos;
        logic [COUNT_BITS-1:0] c;
        if (int'(v) >= VALUE_COUNT)
            return;
        c = hit_count[v];
        if (c == '1)
            return;
        c = c + 1'b1;
        hit_count[v] = c;
        pos = top_len;
        for (int i = 0; i < top_len; i++)
        begin
            if (top_val[i] == v)
            begin
                pos = i;
                break;
            end
        end
        if (pos < top_len)
        begin
            top_cnt[pos] = c;
            sift_up(pos);
        end
        else if (top_len < MAX_K)
        begin
            top_val[pos] = v;
            top_cnt[pos] = c;
            top_len++;
            sift_up(pos);
        end
        else if (ahead_of(v, c, top_val[MAX_K-1], top_cnt[MAX_K-1]))
        begin
            top_val[MAX_K-1] = v;
            top_cnt[MAX_K-1] = c;
            sift_up(MAX_K - 1);
        end
    endfunction

    // queue the ranking report of one word, then count it
    function automatic void predict_report(input logic [VALUE_W-1:0] v);
        int       k;
        int       n;
        tkf_rec_t r;
        k = int'(k_cfg);
        if (k < 1)
            k = 1;
        if (k > MAX_K)
            k = MAX_K;
        n = (top_len < k) ? top_len : k;
        for (int i = 0; i < n; i++)
        begin
            r.query_value       = v;
            r.recommended_value = top_val[i];
            r.rank              = i[RANK_W-1:0];
            r.last              = (i == n - 1);
            rec_due.push_back(r);
        end
        tally_hit(v);
    endfunction

    // mostly repeats of a skewed hot set, the rest spread over the full range
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return hot_pool[$urandom_range(0, $urandom_range(0, HOT_N - 1))];
        return VALUE_W'($urandom_range(0, VALUE_COUNT - 1));
    endfunction

    // apb write: setup cycle, then access cycle
    task automatic set_top_k(input logic [TOPK_W-1:0] k);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOP_K, 2'b00};
        pwdata  <= APB_DW'(k);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        k_cfg = k;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold off until every queued word is taken and every report is back
    task automatic drain();
        @(posedge clk);
        while (pending_items.size() != 0 || item_bus.valid || rec_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(pick_value());
        drain();
    endtask

    // sender: bursts of words separated by random gaps, no gaps when calm
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_bus.valid && !item_taken)
            begin
                // word still waiting for ready
            end
            else if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                item_bus.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item_bus.valid           <= 1'b1;
                item_bus.data.item_value <= pending_items.pop_front();
                if (burst_left > 1)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    if (calm)
                        gap_left = 0;
                    else if ($urandom_range(0, 99) < 50)
                        gap_left = $urandom_range(1, 4);
                    else if ($urandom_range(0, 99) < 70)
                        gap_left = $urandom_range(5, 20);
                    else
                        gap_left = $urandom_range(21, 60);
                end
            end
            else
                item_bus.valid <= 1'b0;
        end
    end

    // receiver: short random stalls plus occasional long ones, always ready when calm
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm)
                rec_bus.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                rec_bus.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 6)
            begin
                stall_left = $urandom_range(1, 30);
                rec_bus.ready <= 1'b0;
            end
            else
                rec_bus.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // monitor: predict on accepted input words, check accepted result words
    always @(posedge clk)
    begin
        item_taken = item_bus.valid && item_bus.ready;
        if (rst_n && item_taken)
            predict_report(item_bus.data.item_value);
        if (rst_n && rec_bus.valid && rec_bus.ready)
        begin
            got = rec_bus.data;
            if (rec_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected word: query %0d value %0d rank %0d last %0d",
                             got.query_value, got.recommended_value, got.rank, got.last);
            end
            else
            begin
                want = rec_due.pop_front();
                if (got.query_value !== want.query_value ||
                    got.recommended_value !== want.recommended_value ||
                    got.rank !== want.rank || got.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: exp q %0d v %0d r %0d l %0d, ",
                                  "got q %0d v %0d r %0d l %0d"},
                                 want.query_value, want.recommended_value, want.rank,
                                 want.last, got.query_value, got.recommended_value,
                                 got.rank, got.last);
                end
            end
        end
        // watchdog on cycles with no accepted word
        if (item_taken || (rec_bus.valid && rec_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.data  = '0;
        rec_bus.ready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        item_taken     = 1'b0;
        calm           = 1'b0;
        err_count      = 0;
        idle_cycles    = 0;
        gap_left       = 0;
        burst_left     = 0;
        stall_left     = 0;
        top_len        = 0;
        k_cfg          = TOPK_RESET;
        foreach (hit_count[i])
            hit_count[i] = '0;
        foreach (top_val[i])
        begin
            top_val[i] = '0;
            top_cnt[i] = '0;
        end
        foreach (hot_pool[i])
            hot_pool[i] = VALUE_W'($urandom_range(0, VALUE_COUNT - 1));
        hot_pool[0] = '0;
        hot_pool[1] = '1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at the reset setting of top_k
        foreach (opening[i])
            pending_items.push_back(opening[i]);
        drain();

        set_top_k(5'd1);
        random_phase(50);
        set_top_k(5'd16);
        random_phase(70);
        // zero is taken as one; no idling on either side here
        calm = 1'b1;
        set_top_k(5'd0);
        random_phase(40);
        calm = 1'b0;
        // above the list size is taken as the list size
        set_top_k(5'd31);
        random_phase(60);
        set_top_k(5'd17);
        random_phase(30);
        set_top_k(TOPK_W'($urandom_range(2, 15)));
        random_phase(60);
        set_top_k(TOPK_RESET);
        random_phase(50);

        if (err_count == 0 && rec_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
sv/tkf_pkg.sv
sv/tkf_ifs.sv
sv/tkf_ram.sv
sv/tkf_apb_regs.sv
sv/tkf_seq.sv
sv/stream_top_k_frequency_recommender.sv
tb/tb_stream_top_k_frequency_recommender.sv
